@@ hw/rtl/nearest_sample_inside_test_unit_macros.svh @@
// Assertion helpers for the checker file nsit_checker.sv.
`ifndef NEAREST_SAMPLE_INSIDE_TEST_UNIT_MACROS_SVH
`define NEAREST_SAMPLE_INSIDE_TEST_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define NSIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define NSIT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/nsit_pkg.sv @@
`timescale 1ns / 1ps

package nsit_pkg;

  localparam int unsigned CoordBitsDef = 16;

endpackage

@@ hw/rtl/nsit_in_if.sv @@
`timescale 1ns / 1ps

interface nsit_in_if #(
  parameter int unsigned COORD_BITS = nsit_pkg::CoordBitsDef
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] query_z;
  logic signed [COORD_BITS-1:0] surf_x;
  logic signed [COORD_BITS-1:0] surf_y;
  logic signed [COORD_BITS-1:0] surf_z;
  logic signed [COORD_BITS-1:0] normal_x;
  logic signed [COORD_BITS-1:0] normal_y;
  logic signed [COORD_BITS-1:0] normal_z;
  logic                         last_sample;

  modport source (
    output valid, query_x, query_y, query_z, surf_x, surf_y, surf_z,
           normal_x, normal_y, normal_z, last_sample,
    input  ready
  );

  modport sink (
    input  valid, query_x, query_y, query_z, surf_x, surf_y, surf_z,
           normal_x, normal_y, normal_z, last_sample,
    output ready
  );
endinterface

@@ hw/rtl/nsit_out_if.sv @@
`timescale 1ns / 1ps

interface nsit_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

@@ hw/rtl/nearest_sample_inside_test_unit.sv @@
`timescale 1ns / 1ps

// Nearest-sample inside test. Stream the surface samples of one query as
// words on sample_i, the query point repeated on each, and mark the final
// sample with last_sample. The unit keeps the sample at the smallest squared
// distance (the earlier one on a tie) and, on the last word, returns one word
// on result_o: inside_res is 1 when (sample - query) . normal of that sample
// is strictly positive. Its running state then clears for the next query.
// One sample word is taken every clock cycle while sample_i.ready is high.
// A result passes three registers: the difference register, the register
// behind the six 17-bit multipliers and the result register after the
// distance compare. sample_i.ready drops only while a result word waits on
// result_o and a further last sample has reached the compare stage.
module nearest_sample_inside_test_unit #(
  parameter int unsigned COORD_BITS = nsit_pkg::CoordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsit_in_if.sink    sample_i,
  nsit_out_if.source result_o
);

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned DotPBits = DiffBits + COORD_BITS;
  localparam int unsigned DistBits = 2 * COORD_BITS + 2;
  localparam int unsigned DotBits  = 2 * COORD_BITS + 2;

  logic                         v1_q;
  logic                         last1_q;
  logic signed [DiffBits-1:0]   dx_q, dy_q, dz_q;
  logic signed [COORD_BITS-1:0] nx_q, ny_q, nz_q;

  logic                         v2_q;
  logic                         last2_q;
  logic        [DistBits-1:0]   sqx_q, sqy_q, sqz_q;
  logic signed [DotPBits-1:0]   pdx_q, pdy_q, pdz_q;

  logic                         best_facing_q;
  logic        [DistBits-1:0]   best_dist_q;
  logic                         out_valid_q;
  logic                         out_res_q;

  logic signed [DiffBits-1:0]   dx_d, dy_d, dz_d;
  logic signed [2*DiffBits-1:0] sqx_full, sqy_full, sqz_full;
  logic signed [DotPBits-1:0]   pdx_full, pdy_full, pdz_full;
  logic        [DistBits-1:0]   dist_sum;
  logic signed [DotBits-1:0]    dot_sum;
  logic                         dot_pos;
  logic                         closer;
  logic                         adv2, rdy2, adv1, in_rdy;
  logic                         in_fire, out_fire;

  assign in_fire  = sample_i.valid && in_rdy;
  assign out_fire = out_valid_q && result_o.ready;

  assign adv2   = v2_q && (!last2_q || !out_valid_q || result_o.ready);
  assign rdy2   = !v2_q || adv2;
  assign adv1   = v1_q && rdy2;
  assign in_rdy = !v1_q || adv1;

  assign dx_d = DiffBits'(sample_i.surf_x) - DiffBits'(sample_i.query_x);
  assign dy_d = DiffBits'(sample_i.surf_y) - DiffBits'(sample_i.query_y);
  assign dz_d = DiffBits'(sample_i.surf_z) - DiffBits'(sample_i.query_z);

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign sqz_full = dz_q * dz_q;

  assign pdx_full = dx_q * nx_q;
  assign pdy_full = dy_q * ny_q;
  assign pdz_full = dz_q * nz_q;

  assign dist_sum = sqx_q + sqy_q + sqz_q;
  assign dot_sum  = DotBits'(pdx_q) + DotBits'(pdy_q) + DotBits'(pdz_q);
  assign dot_pos  = !dot_sum[DotBits-1] && (|dot_sum);
  assign closer   = dist_sum < best_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      out_valid_q   <= 1'b0;
      best_dist_q   <= '1;
      best_facing_q <= 1'b0;
    end else begin
      if (in_fire) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        v2_q <= 1'b1;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end
      if (adv2 && last2_q) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (adv2) begin
        if (last2_q) begin
          best_dist_q   <= '1;
          best_facing_q <= 1'b0;
        end else if (closer) begin
          best_dist_q   <= dist_sum;
          best_facing_q <= dot_pos;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last1_q <= sample_i.last_sample;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dz_q    <= dz_d;
      nx_q    <= sample_i.normal_x;
      ny_q    <= sample_i.normal_y;
      nz_q    <= sample_i.normal_z;
    end
    if (adv1) begin
      last2_q <= last1_q;
      sqx_q   <= DistBits'(unsigned'(sqx_full));
      sqy_q   <= DistBits'(unsigned'(sqy_full));
      sqz_q   <= DistBits'(unsigned'(sqz_full));
      pdx_q   <= pdx_full;
      pdy_q   <= pdy_full;
      pdz_q   <= pdz_full;
    end
    if (adv2 && last2_q) begin
      out_res_q <= closer ? dot_pos : best_facing_q;
    end
  end

  assign sample_i.ready      = in_rdy;
  assign result_o.valid      = out_valid_q;
  assign result_o.inside_res = out_res_q;

endmodule

@@ hw/rtl/nsit_checker.sv @@
`timescale 1ns / 1ps
`include "nearest_sample_inside_test_unit_macros.svh"

module nsit_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_res_i
);

  `NSIT_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_i, "result word shown during reset")
  `NSIT_ASSERT(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_res_i), "stalled result word dropped or changed")
  `NSIT_ASSERT(a_free_ready, !out_valid_i |-> in_ready_i, "sample word refused with result side empty")
  `NSIT_ASSERT(a_last_answers, (in_valid_i && in_ready_i && in_last_i) ##1 out_ready_i ##1 out_ready_i |=> out_valid_i, "no result word after last sample")

endmodule

bind nearest_sample_inside_test_unit nsit_checker u_nsit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_last_i   (sample_i.last_sample),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_res_i   (result_o.inside_res)
);
